// ===== rtl/tpet_pkg.sv =====
// Shared types, constants and UID masking for the tag presence edge tracker.
// No dependencies; imported by tpet_slot and tag_presence_edge_tracker.
package tpet_pkg;

	localparam int PLAYERS_DEF = 2;
	localparam int READERS_DEF = 4;

	localparam int UID_LOW_W  = 64;
	localparam int UID_HIGH_W = 16;
	localparam int LEN_W      = 4;
	localparam int CNT_W      = 8;
	localparam int TIMEOUT_W  = 8;
	localparam int ENABLE_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [LEN_W-1:0]     MAX_UID_LEN = 4'd10;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 8'd30;
	localparam logic [ENABLE_W-1:0]  ENABLE_RST  = 2'b11;
	localparam logic [CNT_W-1:0]     CNT_MAX     = 8'hFF;

	localparam logic CMD_REPORT = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 1'd1;

	typedef struct packed {
		logic [UID_LOW_W-1:0]  low;
		logic [UID_HIGH_W-1:0] high;
		logic [LEN_W-1:0]      length;
	} uid_t;

	typedef struct packed {
		logic age;
		logic clear_seen;
		logic hit;
		logic write;
	} slot_ctl_t;

	// saturate the length and zero every byte at or past it
	function automatic uid_t mask_uid(input logic [UID_LOW_W-1:0] low,
			input logic [UID_HIGH_W-1:0] high, input logic [LEN_W-1:0] length);
		uid_t r;
		logic [LEN_W-1:0] len;
		len = (length > MAX_UID_LEN) ? MAX_UID_LEN : length;
		r.length = len;
		for (int i = 0; i < UID_LOW_W / 8; i++) begin
			r.low[8*i +: 8] = (len > LEN_W'(i)) ? low[8*i +: 8] : 8'h00;
		end
		for (int i = 0; i < UID_HIGH_W / 8; i++) begin
			r.high[8*i +: 8] = (len > LEN_W'(i + UID_LOW_W / 8)) ? high[8*i +: 8] : 8'h00;
		end
		return r;
	endfunction

endpackage

// ===== rtl/tag_presence_edge_tracker.sv =====
// Top level of the tag presence edge tracker: input register, slot grid and
// event output register. Depends on tpet_pkg and tpet_slot.
// Usage:
//   Item channel (item_valid / item_stall) carries card reports (cmd 0) and
//   end-of-frame ticks (cmd 1). Event channel (event_valid / event_stall)
//   carries one word per report whose UID differs from the one stored on
//   its slot (player, reader). Reports for an absent reader, absent player
//   or disabled player are dropped.
//   Flow: an accepted word is registered in the input register; as it leaves
//   that register it updates the slot state and registers its event.
//   Throughput: one word per cycle while no event is held by event_stall;
//   every slot sits in flops and a tick ages all slots of enabled players in the same cycle.
//   Stall: a waiting event holds while event_stall is high; one more word
//   is taken into the input register, then item_stall rises until the
//   event is taken.
//   Reset: all stored tags, counters and seen marks clear; removal_timeout
//   returns to 30 and player_enable to both players.
//   Configuration: cfg_we writes cfg_data to register cfg_index (0 removal_timeout,
//   1 player_enable); the user must write only while no word is in flight, unenforced here.
module tag_presence_edge_tracker #(
	parameter int PLAYERS = tpet_pkg::PLAYERS_DEF,
	parameter int READERS = tpet_pkg::READERS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tpet_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tpet_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic                                cmd,
	input  logic                                player,
	input  logic [2:0]                          reader,
	input  logic [tpet_pkg::UID_LOW_W-1:0]      uid_low,
	input  logic [tpet_pkg::UID_HIGH_W-1:0]     uid_high,
	input  logic [tpet_pkg::LEN_W-1:0]          uid_length,
	output logic                                event_valid,
	input  logic                                event_stall,
	output logic                                event_player,
	output logic [2:0]                          event_reader,
	output logic [tpet_pkg::UID_LOW_W-1:0]      event_uid_low,
	output logic [tpet_pkg::UID_HIGH_W-1:0]     event_uid_high,
	output logic [tpet_pkg::LEN_W-1:0]          event_uid_length
);
	import tpet_pkg::*;

	localparam int SLOTS  = PLAYERS * READERS;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [TIMEOUT_W-1:0] removal_timeout_q;
	logic [ENABLE_W-1:0]  player_enable_q;

	logic       valid_s1;
	logic       cmd_s1;
	logic       player_s1;
	logic [2:0] reader_s1;
	uid_t       uid_s1;

	logic       event_valid_q;
	logic       event_player_q;
	logic [2:0] event_reader_q;
	uid_t       event_uid_q;

	uid_t              stored [SLOTS];
	slot_ctl_t         ctl    [SLOTS];
	logic [SLOT_W-1:0] slot_idx;
	uid_t              sel_uid;
	logic              blocked;
	logic              fire;
	logic              report_ok;
	logic              differ;
	logic              emit;
	logic              tick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			removal_timeout_q <= TIMEOUT_RST;
			player_enable_q   <= ENABLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TIMEOUT: removal_timeout_q <= cfg_data[TIMEOUT_W-1:0];
				REG_ENABLE:  player_enable_q   <= cfg_data[ENABLE_W-1:0];
				default: ;
			endcase
		end
	end

	assign blocked    = event_valid_q && event_stall;
	assign fire       = valid_s1 && !blocked;
	assign item_stall = valid_s1 && blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			cmd_s1    <= cmd;
			player_s1 <= player;
			reader_s1 <= reader;
			uid_s1    <= mask_uid(uid_low, uid_high, uid_length);
		end
	end

	assign tick      = fire && (cmd_s1 == CMD_TICK);
	assign report_ok = fire && (cmd_s1 == CMD_REPORT) && (int'(player_s1) < PLAYERS)
		&& (int'(reader_s1) < READERS) && player_enable_q[player_s1];
	assign slot_idx  = SLOT_W'(int'(player_s1) * READERS + int'(reader_s1));
	assign sel_uid   = stored[slot_idx];
	assign differ    = (sel_uid != uid_s1);
	assign emit      = report_ok && differ;

	for (genvar s = 0; s < SLOTS; s++) begin : g_slot
		always_comb begin
			ctl[s].age        = tick && player_enable_q[s / READERS];
			ctl[s].clear_seen = tick;
			ctl[s].hit        = report_ok && (slot_idx == SLOT_W'(s));
			ctl[s].write      = differ;
		end

		tpet_slot u_slot (
			.clk             (clk),
			.arst_n          (arst_n),
			.ctl             (ctl[s]),
			.new_uid         (uid_s1),
			.removal_timeout (removal_timeout_q),
			.stored          (stored[s])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_valid_q <= 1'b0;
		end else if (fire) begin
			event_valid_q <= emit;
		end else if (!event_stall) begin
			event_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			event_player_q <= player_s1;
			event_reader_q <= reader_s1;
			event_uid_q    <= uid_s1;
		end
	end

	assign event_valid      = event_valid_q;
	assign event_player     = event_player_q;
	assign event_reader     = event_reader_q;
	assign event_uid_low    = event_uid_q.low;
	assign event_uid_high   = event_uid_q.high;
	assign event_uid_length = event_uid_q.length;

endmodule

// ===== rtl/tpet_slot.sv =====
// One reader slot: stored UID, silence counter and seen-this-frame mark.
// Depends on tpet_pkg.
module tpet_slot (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tpet_pkg::slot_ctl_t                ctl,
	input  tpet_pkg::uid_t                     new_uid,
	input  logic [tpet_pkg::TIMEOUT_W-1:0]     removal_timeout,
	output tpet_pkg::uid_t                     stored
);
	import tpet_pkg::*;

	uid_t             uid_q;
	logic [CNT_W-1:0] cnt_q;
	logic             seen_q;
	logic [CNT_W-1:0] cnt_inc;

	assign cnt_inc = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + CNT_W'(1);
	assign stored  = uid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uid_q  <= '0;
			cnt_q  <= '0;
			seen_q <= 1'b0;
		end else begin
			if (ctl.hit) begin
				seen_q <= 1'b1;
				cnt_q  <= '0;
				if (ctl.write) begin
					uid_q <= new_uid;
				end
			end
			if (ctl.age && !seen_q) begin
				if (cnt_inc >= removal_timeout) begin
					uid_q <= '0;
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_inc;
				end
			end
			if (ctl.clear_seen) begin
				seen_q <= 1'b0;
			end
		end
	end

endmodule
